/* rtl/live_block_bitmap_checker_defines.svh */
// assertion macros shared by the bitmap checker rtl
// no dependencies; included by files that carry concurrent checks
`ifndef LIVE_BLOCK_BITMAP_CHECKER_DEFINES_SVH
`define LIVE_BLOCK_BITMAP_CHECKER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define LBBC_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define LBBC_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/lbbc_pkg.sv */
// shared types and constants for the live block bitmap checker
// no dependencies; used by lbbc_mask and live_block_bitmap_checker
package lbbc_pkg;

  localparam int WIN_LOG2   = 20;                  // tracked window is 2^WIN_LOG2 bytes
  localparam int WORD_AW    = WIN_LOG2 - 9;        // 64 granules of 8 bytes per word
  localparam int WORDS      = 1 << WORD_AW;
  localparam int MAP_W      = 64;
  localparam int BIT_IDX_W  = 6;
  localparam int CFG_W      = 21;
  localparam logic [CFG_W-1:0] LARGEST_RESET = 21'h100000;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef logic [WORD_AW-1:0] word_idx_t;

  // granule bit range inside one bitmap word
  typedef struct packed {
    logic [BIT_IDX_W-1:0] lo;
    logic [BIT_IDX_W-1:0] hi;
  } span_t;

endpackage

/* rtl/lbbc_ram.sv */
// generic single write port, single read port ram with registered read
// no dependencies; holds the live bitmap
module lbbc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/lbbc_mask.sv */
// shift unit that turns a granule span into a 64-bit word mask
// depends on lbbc_pkg
module lbbc_mask (
  input  lbbc_pkg::span_t           span,
  output logic [lbbc_pkg::MAP_W-1:0] mask
);

  logic [lbbc_pkg::MAP_W-1:0] upper;
  logic [lbbc_pkg::MAP_W-1:0] lower;

  // ~hi equals 63 - hi for a six bit index
  assign upper = {lbbc_pkg::MAP_W{1'b1}} >> (~span.hi);
  assign lower = {lbbc_pkg::MAP_W{1'b1}} << span.lo;
  assign mask  = upper & lower;

endmodule

/* rtl/live_block_bitmap_checker.sv */
// top level: sequencer that walks the live bitmap one word at a time
// depends on lbbc_pkg, lbbc_ram, lbbc_mask and live_block_bitmap_checker_defines.svh
//
//  channel | dir | handshake            | payload
//  in_     | in  | in_tvalid/in_tready  | tuser operation, tdata address, block_size
//  out_    | out | out_tvalid/out_tready| tdata overlap, rejected
//  cfg_    | in  | cfg_valid/cfg_ready  | cfg_data largest_block
//
// after reset a clearing pass writes all 2048 bitmap words, no request taken
// a request is latched, checked, then each bitmap word touched is read and modified, then posted
// a rejected request skips the word walk; the per-word cost is the ram read-modify-write
// in_tready is high only while idle; a posted result waits in the output register
// cfg writes are taken in every cycle
`include "live_block_bitmap_checker_defines.svh"

module live_block_bitmap_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic        in_tuser,        // [0] operation
  input  logic [63:0] in_tdata,        // [31:0] address, [63:32] block_size
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,       // [0] overlap, [1] rejected, [7:2] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [lbbc_pkg::CFG_W-1:0] cfg_data  // [20:0] largest_block
);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_CHECK  = 3'd2;
  localparam logic [2:0] ST_READ   = 3'd3;
  localparam logic [2:0] ST_MODIFY = 3'd4;
  localparam logic [2:0] ST_FINISH = 3'd5;

  logic [2:0]                       state_r, state_nxt;
  lbbc_pkg::word_idx_t              word_r, word_nxt;
  lbbc_pkg::word_idx_t              last_r, last_nxt;
  logic                             first_r, first_nxt;
  logic [lbbc_pkg::BIT_IDX_W-1:0]   lo_r, lo_nxt;
  logic [lbbc_pkg::BIT_IDX_W-1:0]   hi_r, hi_nxt;
  logic                             ovl_r, ovl_nxt;
  logic                             rej_r, rej_nxt;
  logic                             op_r;
  logic [31:0]                      addr_r;
  logic [31:0]                      size_r;
  logic [lbbc_pkg::CFG_W-1:0]       largest_r;
  logic                             out_valid_r, out_valid_nxt;
  logic                             out_ovl_r;
  logic                             out_rej_r;

  logic                             in_acc;
  logic [32:0]                      end_m1;
  logic                             reject;
  lbbc_pkg::span_t                  span;
  logic [lbbc_pkg::MAP_W-1:0]       mask;
  logic                             ram_wr_en;
  lbbc_pkg::word_idx_t              ram_wr_addr;
  logic [lbbc_pkg::MAP_W-1:0]       ram_wr_data;
  logic                             ram_rd_en;
  logic [lbbc_pkg::MAP_W-1:0]       ram_rd_data;
  logic                             at_last;
  logic                             post;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_rej_r, out_ovl_r};

  // inclusive end of the range, wide enough to see a run past the window
  assign end_m1 = {1'b0, addr_r} + {1'b0, size_r} - 33'd1;
  assign reject = (addr_r == 32'd0) || (size_r == 32'd0) ||
                  (size_r > {{(32 - lbbc_pkg::CFG_W){1'b0}}, largest_r}) ||
                  (|addr_r[31:lbbc_pkg::WIN_LOG2]) ||
                  (|end_m1[32:lbbc_pkg::WIN_LOG2]);

  assign at_last = (word_r == last_r);
  assign span.lo = first_r ? lo_r : '0;
  assign span.hi = at_last ? hi_r : '1;

  lbbc_mask u_mask (
    .span (span),
    .mask (mask)
  );

  assign ram_rd_en   = (state_r == ST_READ);
  assign ram_wr_en   = (state_r == ST_CLEAR) || (state_r == ST_MODIFY);
  assign ram_wr_addr = word_r;
  always_comb begin
    if (state_r == ST_CLEAR) begin
      ram_wr_data = '0;
    end else if (op_r == lbbc_pkg::OP_FREE) begin
      ram_wr_data = ram_rd_data & ~mask;
    end else begin
      ram_wr_data = ram_rd_data | mask;
    end
  end

  lbbc_ram #(
    .WIDTH (lbbc_pkg::MAP_W),
    .DEPTH (lbbc_pkg::WORDS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (word_r),
    .rd_data (ram_rd_data)
  );

  assign post = (state_r == ST_FINISH) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt     = state_r;
    word_nxt      = word_r;
    last_nxt      = last_r;
    first_nxt     = first_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    ovl_nxt       = ovl_r;
    rej_nxt       = rej_r;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      ST_CLEAR: begin
        word_nxt = word_r + 1'b1;
        if (word_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        ovl_nxt   = 1'b0;
        rej_nxt   = reject;
        word_nxt  = addr_r[lbbc_pkg::WIN_LOG2-1:9];
        last_nxt  = end_m1[lbbc_pkg::WIN_LOG2-1:9];
        lo_nxt    = addr_r[8:3];
        hi_nxt    = end_m1[8:3];
        first_nxt = 1'b1;
        state_nxt = reject ? ST_FINISH : ST_READ;
      end
      ST_READ: begin
        state_nxt = ST_MODIFY;
      end
      ST_MODIFY: begin
        if (op_r == lbbc_pkg::OP_ALLOC && (|(ram_rd_data & mask))) begin
          ovl_nxt = 1'b1;
        end
        first_nxt = 1'b0;
        if (at_last) begin
          state_nxt = ST_FINISH;
        end else begin
          word_nxt  = word_r + 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_FINISH: begin
        if (post) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      word_r      <= '0;
      last_r      <= '0;
      first_r     <= 1'b0;
      ovl_r       <= 1'b0;
      rej_r       <= 1'b0;
      out_valid_r <= 1'b0;
      largest_r   <= lbbc_pkg::LARGEST_RESET;
    end else begin
      state_r     <= state_nxt;
      word_r      <= word_nxt;
      last_r      <= last_nxt;
      first_r     <= first_nxt;
      ovl_r       <= ovl_nxt;
      rej_r       <= rej_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        largest_r <= cfg_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
    if (in_acc) begin
      op_r   <= in_tuser;
      addr_r <= in_tdata[31:0];
      size_r <= in_tdata[63:32];
    end
    if (post) begin
      out_ovl_r <= ovl_r && !rej_r;
      out_rej_r <= rej_r;
    end
  end

  `LBBC_ASSERT_NOW(a_no_req_in_clear, clk, rst_n, state_r == ST_CLEAR, !in_tready, "request taken during clearing pass")
  `LBBC_ASSERT_NEXT(a_accept_to_check, clk, rst_n, in_acc, state_r == ST_CHECK, "accepted request did not move to check")
  `LBBC_ASSERT_NOW(a_write_states, clk, rst_n, ram_wr_en, state_r == ST_CLEAR || state_r == ST_MODIFY, "bitmap written outside clear or modify")
  `LBBC_ASSERT_NOW(a_rej_no_ovl, clk, rst_n, out_valid_r, !(out_ovl_r && out_rej_r), "rejected result reports overlap")
  `LBBC_ASSERT_NOW(a_word_in_range, clk, rst_n, state_r == ST_MODIFY, word_r <= last_r, "word walk ran past the last word")

endmodule
